// ===== hdl/ls_pkg.sv =====
`default_nettype none
package ls_pkg;

   localparam int LAP_COUNT_WIDTH = 16;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_ADVANCE = 2'd1,
      MODE_LAP     = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RUN   = 2'd1,
      PH_PAUSE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  phase_now;
      logic [31:0] elapsed_ms;
      logic        lap_event;
      logic [15:0] lap_number;
      logic [31:0] lap_split_ms;
      logic        lap_is_best;
      logic        lap_is_worst;
      logic        reset_alert;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hdl/ls_if.sv =====
`default_nettype none
interface ls_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] now_ms;

   modport source (output valid, output mode, output now_ms, input ready);
   modport sink (input valid, input mode, input now_ms, output ready);
endinterface

interface ls_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  phase_now;
   logic [31:0] elapsed_ms;
   logic        lap_event;
   logic [15:0] lap_number;
   logic [31:0] lap_split_ms;
   logic        lap_is_best;
   logic        lap_is_worst;
   logic        reset_alert;

   modport source (
      output valid, output phase_now, output elapsed_ms, output lap_event,
      output lap_number, output lap_split_ms, output lap_is_best,
      output lap_is_worst, output reset_alert, input ready
   );
   modport sink (
      input valid, input phase_now, input elapsed_ms, input lap_event,
      input lap_number, input lap_split_ms, input lap_is_best,
      input lap_is_worst, input reset_alert, output ready
   );
endinterface
`default_nettype wire

// ===== hdl/lap_stopwatch.sv =====
// Stopwatch with lap timer, one command per item.
// req_chan carries mode (tick, advance phase, record lap) and now_ms, the
// free-running millisecond time. rsp_chan returns exactly one result per
// item: phase, displayed elapsed time, and lap split / number / best and
// worst flags when the item recorded a lap, plus an alert on the
// paused-to-idle reset.
// Both channels use valid/ready; an item moves when both are high.
// Path: an item is registered in the input register on entry, processed
// by the phase logic and lands in the result register once that register
// is free, that is empty or being taken by rsp_chan.
// Throughput: one item per cycle while rsp_chan does not stall, held by
// the update of the phase and lap state between the two registers.
// When rsp_chan stalls, the result register holds and one more item can
// wait in the input register; req_chan.ready drops only when both are full.
// Reset (synchronous, active high) empties both registers and puts the
// watch in idle with laps and records cleared.
`default_nettype none
module lap_stopwatch
   import ls_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   ls_req_if.sink   req_chan,
   ls_rsp_if.source rsp_chan
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_rsp;
   req_type req_item;

   logic out_free;
   logic step;
   logic req_fire;
   logic rsp_fire;

   assign req_item.mode   = req_chan.mode;
   assign req_item.now_ms = req_chan.now_ms;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = out_valid_ff && rsp_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (step) begin
         out_data_ff <= core_rsp;
      end
   end

   ls_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (step),
      .item    (in_item_ff),
      .result  (core_rsp)
   );

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.phase_now    = out_data_ff.phase_now;
   assign rsp_chan.elapsed_ms   = out_data_ff.elapsed_ms;
   assign rsp_chan.lap_event    = out_data_ff.lap_event;
   assign rsp_chan.lap_number   = out_data_ff.lap_number;
   assign rsp_chan.lap_split_ms = out_data_ff.lap_split_ms;
   assign rsp_chan.lap_is_best  = out_data_ff.lap_is_best;
   assign rsp_chan.lap_is_worst = out_data_ff.lap_is_worst;
   assign rsp_chan.reset_alert  = out_data_ff.reset_alert;

endmodule
`default_nettype wire

// ===== hdl/ls_core.sv =====
`default_nettype none
module ls_core
   import ls_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire req_type item,
   output rsp_type      result
);

   phase_type                  phase_ff, phase_in;
   logic [31:0]                start_ff, start_in;
   logic [31:0]                paused_ff, paused_in;
   logic [LAP_COUNT_WIDTH-1:0] laps_ff, laps_in;
   logic [31:0]                last_point_ff, last_point_in;
   logic                       any_lap_ff, any_lap_in;
   logic [31:0]                shortest_ff, shortest_in;
   logic [31:0]                longest_ff, longest_in;

   logic [31:0] point;
   logic [31:0] split;
   logic [31:0] laps_wide;
   logic        best;
   logic        worst;
   logic        do_lap;

   assign point = item.now_ms - start_ff;
   assign split = point - last_point_ff;
   assign best  = !any_lap_ff || (split < shortest_ff);
   assign worst = !any_lap_ff || (split > longest_ff);
   assign do_lap = (item.mode == MODE_LAP) && (phase_ff == PH_RUN);

   always_comb begin
      phase_in      = phase_ff;
      start_in      = start_ff;
      paused_in     = paused_ff;
      laps_in       = laps_ff;
      last_point_in = last_point_ff;
      any_lap_in    = any_lap_ff;
      shortest_in   = shortest_ff;
      longest_in    = longest_ff;
      result        = '0;

      if (item.mode == MODE_ADVANCE) begin
         unique case (phase_ff)
            PH_RUN: begin
               paused_in = point;
               phase_in  = PH_PAUSE;
            end
            PH_PAUSE: begin
               phase_in           = PH_IDLE;
               paused_in          = '0;
               laps_in            = '0;
               last_point_in      = '0;
               any_lap_in         = 1'b0;
               result.reset_alert = 1'b1;
            end
            default: begin
               // idle, and the unreachable fourth code, start the run
               start_in = item.now_ms;
               phase_in = PH_RUN;
            end
         endcase
      end else if (do_lap) begin
         last_point_in = point;
         laps_in       = laps_ff + 1'b1;
         any_lap_in    = 1'b1;
         if (best) begin
            shortest_in = split;
         end
         if (worst) begin
            longest_in = split;
         end
         result.lap_event    = 1'b1;
         result.lap_split_ms = split;
         result.lap_is_best  = best;
         result.lap_is_worst = worst;
      end

      laps_wide = 32'(laps_in);
      if (do_lap) begin
         result.lap_number = laps_wide[15:0];
      end

      result.phase_now = phase_in;
      unique case (phase_in)
         PH_RUN:   result.elapsed_ms = item.now_ms - start_in;
         PH_PAUSE: result.elapsed_ms = paused_in;
         default:  result.elapsed_ms = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         start_ff      <= '0;
         paused_ff     <= '0;
         laps_ff       <= '0;
         last_point_ff <= '0;
         any_lap_ff    <= 1'b0;
         shortest_ff   <= '0;
         longest_ff    <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         start_ff      <= start_in;
         paused_ff     <= paused_in;
         laps_ff       <= laps_in;
         last_point_ff <= last_point_in;
         any_lap_ff    <= any_lap_in;
         shortest_ff   <= shortest_in;
         longest_ff    <= longest_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ls_checker.sv =====
`default_nettype none
module ls_checker
   import ls_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_phase_now,
   input wire logic [31:0] rsp_elapsed_ms,
   input wire logic        rsp_lap_event,
   input wire logic [15:0] rsp_lap_number,
   input wire logic [31:0] rsp_lap_split_ms,
   input wire logic        rsp_lap_is_best,
   input wire logic        rsp_lap_is_worst,
   input wire logic        rsp_reset_alert
);

   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_elapsed_ms)
         && $stable(rsp_phase_now) && $stable(rsp_lap_event))
      else $error("result changed while stalled");

   a_no_lap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_lap_event |-> rsp_lap_number == 16'd0
         && rsp_lap_split_ms == 32'd0 && !rsp_lap_is_best && !rsp_lap_is_worst)
      else $error("lap fields set without a lap");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_phase_now == PH_IDLE |-> rsp_elapsed_ms == 32'd0)
      else $error("elapsed time nonzero in idle");

   a_alert_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_reset_alert |-> rsp_phase_now == PH_IDLE && !rsp_lap_event)
      else $error("reset alert outside idle");

   a_lap_running: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_lap_event |-> rsp_phase_now == PH_RUN && !rsp_reset_alert)
      else $error("lap recorded while not running");

endmodule

bind lap_stopwatch ls_checker u_ls_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_phase_now    (rsp_chan.phase_now),
   .rsp_elapsed_ms   (rsp_chan.elapsed_ms),
   .rsp_lap_event    (rsp_chan.lap_event),
   .rsp_lap_number   (rsp_chan.lap_number),
   .rsp_lap_split_ms (rsp_chan.lap_split_ms),
   .rsp_lap_is_best  (rsp_chan.lap_is_best),
   .rsp_lap_is_worst (rsp_chan.lap_is_worst),
   .rsp_reset_alert  (rsp_chan.reset_alert)
);
`default_nettype wire
